// ===== hdl/sss_pkg.sv =====
// Types and constants shared by the stride share scheduler modules.
package sss_pkg;

    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int PCT_W   = 7;
    localparam int SHARE_W = 7;
    localparam int PASS_W  = 52;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [PASS_W-1:0] PASS_LIMIT   = 52'd1000000000000007;
    localparam logic [PASS_W-1:0] PASS_MAX     = '1;
    localparam logic [PCT_W-1:0]  FULL_PERCENT = 7'd100;

    localparam logic [APB_AW-1:0] ADDR_RESERVED_TOTAL = 2'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_REBAL = 2'd1,
        MODE_PICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic               valid;
        logic [PCT_W-1:0]   resv;
        logic [SHARE_W-1:0] share;
        logic [PASS_W-1:0]  pass;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_ACT,
        ST_A_RD,
        ST_A_ACT,
        ST_R_GO,
        ST_R_DIV,
        ST_B_RD,
        ST_B_ACT,
        ST_P_RD,
        ST_P_ACT,
        ST_S_RD,
        ST_S_ACT,
        ST_P_GO,
        ST_P_DIV,
        ST_P_UPD
    } state_t;

endpackage

// ===== hdl/sss_if.sv =====
// Handshake interfaces for the command and result channels.
interface sss_in_if;
    logic                       valid;
    logic                       ready;
    logic [sss_pkg::MODE_W-1:0] mode;
    logic [sss_pkg::SLOT_W-1:0] slot;
    logic                       slot_valid;
    logic [sss_pkg::PCT_W-1:0]  reservation;

    modport source (output valid, output mode, output slot, output slot_valid,
                    output reservation, input ready);
    modport sink (input valid, input mode, input slot, input slot_valid,
                  input reservation, output ready);
endinterface

interface sss_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sss_pkg::SLOT_W-1:0] chosen_slot;

    modport source (output valid, output found, output chosen_slot, input ready);
    modport sink (input valid, input found, input chosen_slot, output ready);
endinterface

// ===== hdl/sss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sss_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module sss_div #(
    parameter int DIVIDEND_W = 30,
    parameter int DIVISOR_W  = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output sss_pkg::div_stat_t       stat,
    output logic [DIVIDEND_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider running with an exhausted count");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> dsr_reg != '0)
        else $error("divider running with a zero divisor");

endmodule

// ===== hdl/stride_share_scheduler.sv =====
// Top level of the stride share scheduler: slot table, sequencer and register port.
//
//  Channel   Dir  Beat contents                               Handshake
//  in_ch     in   mode, slot, slot_valid, reservation         valid/ready
//  out_ch    out  found, chosen_slot                          valid/ready
//  apb       in   reserved_total at byte address 0            psel/penable
//
// A write touches one row, while a rebalance and a pick walk the slot table; a pick
// walks it again when the passes are rebased. The slot table is one RAM row per slot,
// visited through a read state and then an action state per row, and all divisions
// share a single bit-serial divider. Reset clears the control state and the
// row-written marks, so unwritten rows read as zero; no clearing pass is needed.
// A new command is taken when idle and the previous result has gone to the output register.
module stride_share_scheduler #(
    parameter int NUM_SLOTS        = 16,
    parameter int STRIDE_NUMERATOR = 1000000000
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sss_in_if.sink                        in_ch,
    sss_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sss_pkg::APB_AW-1:0]    paddr,
    input  logic [sss_pkg::APB_DW-1:0]    pwdata,
    output logic [sss_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int NW    = $clog2(STRIDE_NUMERATOR + 1);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int PW    = sss_pkg::PASS_W;

    sss_pkg::state_t state_reg, state_next;
    logic            fin_reg, fin_next;

    logic [sss_pkg::PCT_W-1:0]   reserved_total_reg, reserved_total_next;
    logic [NUM_SLOTS-1:0]        init_reg, init_next;
    logic                        rd_init_reg;
    logic [SW-1:0]               idx_reg, idx_next;
    logic [SW-1:0]               wslot_reg, wslot_next;
    logic                        wvalid_reg, wvalid_next;
    logic [sss_pkg::PCT_W-1:0]   wresv_reg, wresv_next;
    logic [CNT_W-1:0]            zcnt_reg, zcnt_next;
    logic [sss_pkg::SHARE_W-1:0] each_reg, each_next;
    logic                        have_reg, have_next;
    logic [PW-1:0]               least_reg, least_next;
    logic [SW-1:0]               best_reg, best_next;
    sss_pkg::row_t               best_row_reg, best_row_next;
    logic                        sub_reg, sub_next;
    logic                        res_found_reg, res_found_next;
    logic [sss_pkg::SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [sss_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;

    logic                    ram_we;
    logic [SW-1:0]           ram_waddr;
    sss_pkg::row_t           ram_wrow;
    logic [SW-1:0]           ram_raddr;
    logic [sss_pkg::ROW_W-1:0] ram_rdata;
    sss_pkg::row_t           row;

    logic                        div_start;
    logic [NW-1:0]               div_dividend;
    logic [sss_pkg::SHARE_W-1:0] div_divisor;
    logic [NW-1:0]               div_quo;
    sss_pkg::div_stat_t          div_stat;

    logic                      in_fire;
    logic                      cfg_write;
    logic                      last;
    logic                      elig;
    logic                      take;
    logic                      have_after;
    logic [PW-1:0]             least_after;
    logic                      zero_resv;
    logic [sss_pkg::PCT_W-1:0] left;
    logic                      slot_ok;
    logic [PW-1:0]             base;
    logic [PW:0]               sum;
    logic                      fin_go;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign row       = rd_init_reg ? sss_pkg::row_t'(ram_rdata) : '0;
    assign last      = (idx_reg == SW'(NUM_SLOTS - 1));
    assign zero_resv = row.valid && (row.resv == '0);
    assign elig      = row.valid && (row.share != '0);
    assign take      = elig && (!have_reg || (row.pass < least_reg));
    assign have_after  = have_reg || elig;
    assign least_after = take ? row.pass : least_reg;
    assign left      = (reserved_total_reg >= sss_pkg::FULL_PERCENT) ? '0
                       : sss_pkg::FULL_PERCENT - reserved_total_reg;
    assign slot_ok   = (32'(in_ch.slot) < NUM_SLOTS);
    assign base      = sub_reg ? '0 : least_reg;
    assign sum       = {1'b0, base} + (PW + 1)'(div_quo);
    assign fin_go    = fin_reg && (!out_valid_reg || out_ch.ready);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        if (fin_go)
        begin
            fin_next = 1'b0;
        end
        unique case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (sss_pkg::mode_t'(in_ch.mode))
                        sss_pkg::MODE_WRITE:
                        begin
                            if (slot_ok)
                            begin
                                state_next = sss_pkg::ST_W_RD;
                            end
                            else
                            begin
                                fin_next = 1'b1;
                            end
                        end
                        sss_pkg::MODE_REBAL: state_next = sss_pkg::ST_A_RD;
                        sss_pkg::MODE_PICK:  state_next = sss_pkg::ST_P_RD;
                        default:             fin_next   = 1'b1;
                    endcase
                end
            end
            sss_pkg::ST_W_RD: state_next = sss_pkg::ST_W_ACT;
            sss_pkg::ST_W_ACT:
            begin
                state_next = sss_pkg::ST_IDLE;
                fin_next   = 1'b1;
            end
            sss_pkg::ST_A_RD: state_next = sss_pkg::ST_A_ACT;
            sss_pkg::ST_A_ACT:
            begin
                if (!last)
                begin
                    state_next = sss_pkg::ST_A_RD;
                end
                else if ((zcnt_reg != '0 || zero_resv) && left != '0)
                begin
                    state_next = sss_pkg::ST_R_GO;
                end
                else
                begin
                    state_next = sss_pkg::ST_IDLE;
                    fin_next   = 1'b1;
                end
            end
            sss_pkg::ST_R_GO: state_next = sss_pkg::ST_R_DIV;
            sss_pkg::ST_R_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sss_pkg::ST_B_RD;
                end
            end
            sss_pkg::ST_B_RD: state_next = sss_pkg::ST_B_ACT;
            sss_pkg::ST_B_ACT:
            begin
                if (last)
                begin
                    state_next = sss_pkg::ST_IDLE;
                    fin_next   = 1'b1;
                end
                else
                begin
                    state_next = sss_pkg::ST_B_RD;
                end
            end
            sss_pkg::ST_P_RD: state_next = sss_pkg::ST_P_ACT;
            sss_pkg::ST_P_ACT:
            begin
                if (!last)
                begin
                    state_next = sss_pkg::ST_P_RD;
                end
                else if (!have_after)
                begin
                    state_next = sss_pkg::ST_IDLE;
                    fin_next   = 1'b1;
                end
                else if (least_after > sss_pkg::PASS_LIMIT)
                begin
                    state_next = sss_pkg::ST_S_RD;
                end
                else
                begin
                    state_next = sss_pkg::ST_P_GO;
                end
            end
            sss_pkg::ST_S_RD: state_next = sss_pkg::ST_S_ACT;
            sss_pkg::ST_S_ACT:
            begin
                state_next = last ? sss_pkg::ST_P_GO : sss_pkg::ST_S_RD;
            end
            sss_pkg::ST_P_GO: state_next = sss_pkg::ST_P_DIV;
            sss_pkg::ST_P_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sss_pkg::ST_P_UPD;
                end
            end
            sss_pkg::ST_P_UPD:
            begin
                state_next = sss_pkg::ST_IDLE;
                fin_next   = 1'b1;
            end
            default: state_next = sss_pkg::ST_IDLE;
        endcase
    end

    // RAM and divider controls.
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wrow     = row;
        ram_raddr    = (state_reg == sss_pkg::ST_W_RD) ? wslot_reg : idx_reg;
        div_start    = 1'b0;
        div_dividend = NW'(STRIDE_NUMERATOR);
        div_divisor  = best_row_reg.share;
        unique case (state_reg)
            sss_pkg::ST_W_ACT:
            begin
                ram_we         = 1'b1;
                ram_waddr      = wslot_reg;
                ram_wrow.valid = wvalid_reg;
                ram_wrow.resv  = wresv_reg;
            end
            sss_pkg::ST_A_ACT:
            begin
                ram_we         = row.valid;
                ram_wrow.share = row.resv;
                ram_wrow.pass  = '0;
            end
            sss_pkg::ST_B_ACT:
            begin
                ram_we         = zero_resv;
                ram_wrow.share = each_reg;
            end
            sss_pkg::ST_S_ACT:
            begin
                ram_we        = elig;
                ram_wrow.pass = row.pass - least_reg;
            end
            sss_pkg::ST_R_GO:
            begin
                div_start    = 1'b1;
                div_dividend = NW'(left);
                div_divisor  = sss_pkg::SHARE_W'(zcnt_reg);
            end
            sss_pkg::ST_P_GO:
            begin
                div_start = 1'b1;
            end
            sss_pkg::ST_P_UPD:
            begin
                ram_we        = 1'b1;
                ram_waddr     = best_reg;
                ram_wrow      = best_row_reg;
                ram_wrow.pass = sum[PW] ? sss_pkg::PASS_MAX : sum[PW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        reserved_total_next = reserved_total_reg;
        init_next      = init_reg;
        idx_next       = idx_reg;
        wslot_next     = wslot_reg;
        wvalid_next    = wvalid_reg;
        wresv_next     = wresv_reg;
        zcnt_next      = zcnt_reg;
        each_next      = each_reg;
        have_next      = have_reg;
        least_next     = least_reg;
        best_next      = best_reg;
        best_row_next  = best_row_reg;
        sub_next       = sub_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_slot_next  = out_slot_reg;

        if (cfg_write && paddr == sss_pkg::ADDR_RESERVED_TOTAL)
        begin
            reserved_total_next = pwdata[sss_pkg::PCT_W-1:0];
        end
        if (ram_we)
        begin
            init_next[ram_waddr] = 1'b1;
        end
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fin_go)
        begin
            out_valid_next = 1'b1;
            out_found_next = res_found_reg;
            out_slot_next  = res_slot_reg;
        end

        case (state_reg) inside
            sss_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next       = '0;
                    wslot_next     = SW'(in_ch.slot);
                    wvalid_next    = in_ch.slot_valid;
                    wresv_next     = in_ch.reservation;
                    zcnt_next      = '0;
                    have_next      = 1'b0;
                    sub_next       = 1'b0;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                end
            end
            sss_pkg::ST_A_ACT:
            begin
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (zero_resv)
                begin
                    zcnt_next = zcnt_reg + 1'b1;
                end
            end
            sss_pkg::ST_R_DIV:
            begin
                if (div_stat.done)
                begin
                    each_next = div_quo[sss_pkg::SHARE_W-1:0];
                end
            end
            sss_pkg::ST_B_ACT, sss_pkg::ST_S_ACT:
            begin
                idx_next = last ? '0 : idx_reg + 1'b1;
            end
            sss_pkg::ST_P_ACT:
            begin
                idx_next   = last ? '0 : idx_reg + 1'b1;
                have_next  = have_after;
                least_next = least_after;
                if (take)
                begin
                    best_next     = idx_reg;
                    best_row_next = row;
                end
                if (last && have_after && least_after > sss_pkg::PASS_LIMIT)
                begin
                    sub_next = 1'b1;
                end
            end
            sss_pkg::ST_P_UPD:
            begin
                res_found_next = 1'b1;
                res_slot_next  = sss_pkg::SLOT_W'(best_reg);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= sss_pkg::ST_IDLE;
            fin_reg            <= 1'b0;
            reserved_total_reg <= '0;
            init_reg           <= '0;
            rd_init_reg        <= 1'b0;
            idx_reg            <= '0;
            zcnt_reg           <= '0;
            have_reg           <= 1'b0;
            sub_reg            <= 1'b0;
            res_found_reg      <= 1'b0;
            res_slot_reg       <= '0;
            out_valid_reg      <= 1'b0;
            out_found_reg      <= 1'b0;
            out_slot_reg       <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            fin_reg            <= fin_next;
            reserved_total_reg <= reserved_total_next;
            init_reg           <= init_next;
            rd_init_reg        <= init_reg[ram_raddr];
            idx_reg            <= idx_next;
            zcnt_reg           <= zcnt_next;
            have_reg           <= have_next;
            sub_reg            <= sub_next;
            res_found_reg      <= res_found_next;
            res_slot_reg       <= res_slot_next;
            out_valid_reg      <= out_valid_next;
            out_found_reg      <= out_found_next;
            out_slot_reg       <= out_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wslot_reg    <= wslot_next;
        wvalid_reg   <= wvalid_next;
        wresv_reg    <= wresv_next;
        each_reg     <= each_next;
        least_reg    <= least_next;
        best_reg     <= best_next;
        best_row_reg <= best_row_next;
    end

    sss_ram #(
        .WIDTH (sss_pkg::ROW_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sss_div #(
        .DIVIDEND_W (NW),
        .DIVISOR_W  (sss_pkg::SHARE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign in_ch.ready        = (state_reg == sss_pkg::ST_IDLE) && !fin_reg;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found       = out_found_reg;
    assign out_ch.chosen_slot = out_slot_reg;
    assign prdata = (paddr == sss_pkg::ADDR_RESERVED_TOTAL)
                    ? sss_pkg::APB_DW'(reserved_total_reg) : '0;
    assign pready = 1'b1;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == sss_pkg::ST_R_DIV || state_reg == sss_pkg::ST_P_DIV))
        else $error("divider result arrived outside a waiting state");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg != sss_pkg::ST_IDLE)
        else $error("slot table written while idle");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_reg))
        else $error("result beat raised without a finished command");

endmodule
